// ===== src/cia_pkg.sv =====
`default_nettype none

package cia_pkg;

  // Width of the checked result range; operands and results must fit in it.
  localparam int unsigned RESULT_BITS = 32;
  // Fixed field widths of the stream payloads.
  localparam int unsigned OPND_BITS   = 64;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned IN_TDATA_BITS  = 136;  // 2 + 64 + 64 rounded to bytes
  localparam int unsigned OUT_TDATA_BITS = 40;   // 32 + 1 rounded to bytes

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  // Payload carried down the divider stages.
  typedef struct packed {
    logic                   is_div;  // quotient is built in rem/quo
    logic                   err;     // error already known
    logic [RESULT_BITS-1:0] res;     // final value for add/sub/mul
    logic                   neg;     // quotient sign
    logic [RESULT_BITS-1:0] dmag;    // divisor magnitude
    logic [RESULT_BITS-1:0] rem;     // partial remainder
    logic [RESULT_BITS-1:0] quo;     // dividend bits in, quotient bits out
  } div_t;

endpackage

`default_nettype wire

// ===== src/cia_div_step.sv =====
`default_nettype none

// One restoring-division step: one quotient bit, registered.
module cia_div_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire cia_pkg::div_t st_i,
  output logic               valid_o,
  output cia_pkg::div_t      st_o
);
  import cia_pkg::*;

  localparam int unsigned W = RESULT_BITS;

  logic [W:0]   shifted;
  logic [W+1:0] trial;
  logic         qbit;
  div_t         st_d;
  div_t         st_q;
  logic         valid_q;

  assign shifted = {st_i.rem, st_i.quo[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, st_i.dmag};
  assign qbit    = ~trial[W+1];

  always_comb begin
    st_d = st_i;
    if (st_i.is_div) begin
      st_d.rem = qbit ? trial[W-1:0] : shifted[W-1:0];
      st_d.quo = {st_i.quo[W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

`default_nettype wire

// ===== src/checked_int32_alu.sv =====
// checked_int32_alu: checked signed ALU (add, sub, mul, div toward zero).
// Input stream s_axis_*: one beat carries cmd and two signed 64-bit operands.
// Output stream m_axis_*: one beat per input beat, in order, with a signed
// 32-bit value and an error bit. Error is set (and value forced to 0) when
// an operand or the exact result leaves the RESULT_BITS signed range, or
// on a zero divisor; minimum / -1 is such an overflow.
// Throughput: one beat per cycle, sustained while the skid is empty, divide included.
// Pipeline: capture/range check (loaded at the accepting edge),
// add/sub/multiply and magnitudes, result checks and divide setup, one
// stage per quotient bit, then the output register.
// The divider is a restoring divider, one quotient bit per stage.
// Reset empties the pipeline and the output; tready is high after reset.
// When the receiver stalls, the output register holds its beat and a
// one-beat skid register catches the next finished result; the pipeline
// then freezes and s_axis_tready_o drops until the skid drains. Items are
// never dropped or repeated.
`default_nettype none

module checked_int32_alu (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [1:0] cmd, [65:2] operand_a, [129:66] operand_b, [135:130] zero
  input  wire logic [cia_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [31:0] value, [32] error, [39:33] zero
  output logic [cia_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata_o
);
  import cia_pkg::*;

  localparam int unsigned W = RESULT_BITS;

  // Pipeline advance: whole pipe moves unless the skid is holding a beat.
  logic pipe_en;

  // ---------------- stage 0: capture and operand range check ----------
  logic [OPND_BITS-1:0] in_a;
  logic [OPND_BITS-1:0] in_b;
  logic                 in_a_ok;
  logic                 in_b_ok;

  logic         s0_valid_q;
  cmd_e         s0_cmd_q;
  logic [W-1:0] s0_a_q;
  logic [W-1:0] s0_b_q;
  logic         s0_oor_q;

  assign in_a = s_axis_tdata_i[CMD_BITS +: OPND_BITS];
  assign in_b = s_axis_tdata_i[CMD_BITS+OPND_BITS +: OPND_BITS];
  // In range when every bit from the sign bit of the range up is equal.
  assign in_a_ok = (&in_a[OPND_BITS-1:W-1]) | ~(|in_a[OPND_BITS-1:W-1]);
  assign in_b_ok = (&in_b[OPND_BITS-1:W-1]) | ~(|in_b[OPND_BITS-1:W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_cmd_q <= cmd_e'(s_axis_tdata_i[CMD_BITS-1:0]);
      s0_a_q   <= in_a[W-1:0];
      s0_b_q   <= in_b[W-1:0];
      s0_oor_q <= ~(in_a_ok & in_b_ok);
    end
  end

  // ---------------- stage 1: add/sub, multiply, magnitudes ------------
  logic [W:0]            s1_sum_d;
  logic signed [2*W-1:0] s1_prod_d;

  logic                  s1_valid_q;
  cmd_e                  s1_cmd_q;
  logic                  s1_oor_q;
  logic [W:0]            s1_sum_q;
  logic [2*W-1:0]        s1_prod_q;
  logic [W-1:0]          s1_amag_q;
  logic [W-1:0]          s1_bmag_q;
  logic                  s1_neg_q;
  logic                  s1_bzero_q;

  assign s1_sum_d = (s0_cmd_q == CMD_SUB)
                  ? ({s0_a_q[W-1], s0_a_q} - {s0_b_q[W-1], s0_b_q})
                  : ({s0_a_q[W-1], s0_a_q} + {s0_b_q[W-1], s0_b_q});
  assign s1_prod_d = $signed(s0_a_q) * $signed(s0_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_cmd_q   <= s0_cmd_q;
      s1_oor_q   <= s0_oor_q;
      s1_sum_q   <= s1_sum_d;
      s1_prod_q  <= s1_prod_d;
      // Magnitude of the minimum is 2^(W-1), which still fits unsigned.
      s1_amag_q  <= s0_a_q[W-1] ? (~s0_a_q + 1'b1) : s0_a_q;
      s1_bmag_q  <= s0_b_q[W-1] ? (~s0_b_q + 1'b1) : s0_b_q;
      s1_neg_q   <= s0_a_q[W-1] ^ s0_b_q[W-1];
      s1_bzero_q <= ~(|s0_b_q);
    end
  end

  // ---------------- stage 2: result checks, divider setup -------------
  div_t s2_d;
  div_t s2_q;
  logic s2_valid_q;
  logic prod_ok;

  assign prod_ok = (&s1_prod_q[2*W-1:W-1]) | ~(|s1_prod_q[2*W-1:W-1]);

  always_comb begin
    s2_d        = '0;
    s2_d.neg    = s1_neg_q;
    s2_d.dmag   = s1_bmag_q;
    s2_d.quo    = s1_amag_q;
    case (s1_cmd_q)
      CMD_ADD, CMD_SUB: begin
        s2_d.err = s1_oor_q | (s1_sum_q[W] ^ s1_sum_q[W-1]);
        s2_d.res = s1_sum_q[W-1:0];
      end
      CMD_MUL: begin
        s2_d.err = s1_oor_q | ~prod_ok;
        s2_d.res = s1_prod_q[W-1:0];
      end
      CMD_DIV: begin
        s2_d.is_div = 1'b1;
        s2_d.err    = s1_oor_q | s1_bzero_q;
      end
      default: begin
        s2_d.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_q <= s2_d;
    end
  end

  // ---------------- divider: one quotient bit per stage ---------------
  div_t dv_st    [W+1];
  logic dv_valid [W+1];

  assign dv_st[0]    = s2_q;
  assign dv_valid[0] = s2_valid_q;

  for (genvar k = 0; k < W; k++) begin : g_div
    cia_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (dv_valid[k]),
      .st_i    (dv_st[k]),
      .valid_o (dv_valid[k+1]),
      .st_o    (dv_st[k+1])
    );
  end

  // ---------------- final: quotient sign and overflow, select ---------
  div_t                  fin;
  logic [W:0]            quo_s;
  logic                  fin_err;
  logic [W-1:0]          fin_res;
  logic [VALUE_BITS-1:0] fin_value;
  logic                  fin_valid;

  assign fin       = dv_st[W];
  assign fin_valid = dv_valid[W];
  assign quo_s     = fin.neg ? (~{1'b0, fin.quo} + 1'b1) : {1'b0, fin.quo};

  always_comb begin
    fin_err = fin.err;
    fin_res = fin.res;
    if (fin.is_div) begin
      // Only minimum / -1 overflows here: +2^(W-1) does not fit.
      fin_err = fin.err | (quo_s[W] ^ quo_s[W-1]);
      fin_res = quo_s[W-1:0];
    end
    fin_value = fin_err ? '0 : VALUE_BITS'(signed'(fin_res));
  end

  // ---------------- output register and skid ---------------------------
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_err_q;
  logic                  skid_valid_q;
  logic [VALUE_BITS-1:0] skid_value_q;
  logic                  skid_err_q;
  logic                  out_take;
  logic                  pipe_leave;
  logic                  out_room;

  assign pipe_en    = ~skid_valid_q;
  assign out_take   = out_valid_q & m_axis_tready_i;
  assign out_room   = ~out_valid_q | m_axis_tready_i;
  assign pipe_leave = pipe_en & fin_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_room) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (pipe_leave) begin
      if (out_room) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_room) begin
        out_value_q <= skid_value_q;
        out_err_q   <= skid_err_q;
      end
    end else if (pipe_leave) begin
      if (out_room) begin
        out_value_q <= fin_value;
        out_err_q   <= fin_err;
      end else begin
        skid_value_q <= fin_value;
        skid_err_q   <= fin_err;
      end
    end
  end

  assign s_axis_tready_o = pipe_en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_BITS-VALUE_BITS-1){1'b0}}, out_err_q, out_value_q};

  // ---------------- assertions -----------------------------------------
  // Skid only ever holds a beat behind a held output beat.
  a_skid_behind_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q
  ) else $error("skid valid without output valid");

  // Skid fills only after a stalled output.
  a_skid_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready_i)
  ) else $error("skid filled without a stall");

  // Error results carry a zero value.
  a_err_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_err_q) |-> (out_value_q == '0)
  ) else $error("error beat with nonzero value");

endmodule

`default_nettype wire
